// File: src/dbh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbh_pkg
// Shared types, codes and fixed-point helpers for the damped BFGS core.
// ----------------------------------------------------------------------------
package dbh_pkg;

  localparam int DIM_DEF = 16;
  localparam int IDX_W   = 6;
  localparam int DATA_W  = 32;
  localparam int ACC_W   = 56;
  localparam int DEN_W   = 36;
  localparam logic signed [31:0] ONE_Q = 32'sd65536;
  localparam logic signed [63:0] LIM61 = 64'sh2000_0000_0000_0000;

  typedef enum logic [1:0] {
    FN_WRITE  = 2'd0,
    FN_LOAD   = 2'd1,
    FN_UPDATE = 2'd2,
    FN_READ   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZDEN = 2'd1,
    ST_SAT  = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_TAKE, OP_CLR, OP_WRITE, OP_LOAD, OP_RDITEM, OP_RD, OP_MUL,
    OP_ACC_CLR, OP_ACC, OP_ST_HS, OP_ST_SHS, OP_ST_SY, OP_ST_R, OP_ST_SR,
    OP_TH_ONE, OP_DIV_TH, OP_TH_ST, OP_OMT, OP_LATCH, OP_DIV1, OP_DIV2,
    OP_UPD_WR, OP_FIN, OP_FIN_ZD
  } op_t;

  typedef enum logic [2:0] {
    M_HS, M_SHS, M_SY, M_TY, M_OH, M_SR, M_HH, M_RR
  } msel_t;

  typedef enum logic [5:0] {
    S_CLEAR, S_IDLE, S_WR, S_LD, S_RD,
    S_HS_CLR, S_HS_RD, S_HS_MUL, S_HS_ACC, S_HS_ST,
    S_SH_CLR, S_SH_RD, S_SH_MUL, S_SH_ACC, S_SH_ST,
    S_SY_CLR, S_SY_RD, S_SY_MUL, S_SY_ACC, S_SY_ST,
    S_TH_CHK, S_TH_ONE, S_TH_DIV, S_TH_WAIT, S_TH_ST, S_OMT,
    S_R_CLR, S_R_RD, S_R_MTY, S_R_ACC1, S_R_MOH, S_R_ACC2, S_R_ST,
    S_SR_CLR, S_SR_RD, S_SR_MUL, S_SR_ACC, S_SR_ST, S_SR_CHK,
    S_UP_ROW, S_UP_LAT, S_UP_RD, S_UP_MHH, S_UP_D1, S_UP_MRR, S_UP_D2,
    S_UP_WAIT, S_UP_WR, S_FIN, S_FIN_ZD
  } state_t;

  typedef struct packed {
    op_t              op;
    msel_t            msel;
    logic [IDX_W-1:0] ri;
    logic [IDX_W-1:0] rj;
    logic [IDX_W-1:0] vi;
  } cmd_t;

  typedef struct packed {
    logic shs_zero;
    logic th_pass;
    logic th_den_zero;
    logic sr_zero;
    logic div_busy;
  } sts_t;

  // Clamp a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] res;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      res = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      res = 32'sh8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  function automatic logic ovf32(input logic signed [63:0] v);
    return (v > 64'sh0000_0000_7FFF_FFFF) || (v < -64'sh0000_0000_8000_0000);
  endfunction

  // Limit a correction term to plus or minus two to the 61st.
  function automatic logic signed [63:0] lim61(input logic signed [63:0] v);
    logic signed [63:0] res;
    if (v > LIM61) begin
      res = LIM61;
    end else if (v < -LIM61) begin
      res = -LIM61;
    end else begin
      res = v;
    end
    return res;
  endfunction

  function automatic logic ovf61(input logic signed [63:0] v);
    return (v > LIM61) || (v < -LIM61);
  endfunction

endpackage

// File: src/damped_bfgs_hessian_update_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// damped_bfgs_hessian_update_core
// Powell-damped BFGS update of a DIM by DIM Q16.16 Hessian estimate.
// ----------------------------------------------------------------------------
// After reset the core writes the identity into its Hessian memory and
// accepts no word until that sweep is done. Write, load and read items
// then each return one result word. An update item needs one more
// division for theta when damping applies, and each new entry waits out
// two 64-step radix-2 divisions, which run on two dividers started one
// after the other; Hs is formed one product at a time on the single
// shared multiplier. One item is handled at a time; the next is taken
// once the previous result word has been or is being taken.
// ----------------------------------------------------------------------------
module damped_bfgs_hessian_update_core #(
  parameter int DIM = dbh_pkg::DIM_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [175:0] in_tdata,   // row[5:0], col[11:6], entry_value[43:12],
                                   // x_old[75:44], x_new[107:76],
                                   // g_old[139:108], g_new[171:140]
  input  logic [1:0]   in_tuser,   // func[1:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [39:0]  out_tdata   // read_value[31:0], damping_used[32],
                                   // status[34:33]
);
  import dbh_pkg::*;

  cmd_t               cmd;
  sts_t               sts;
  logic signed [31:0] read_value;
  logic               damping_used;
  logic [1:0]         status;

  dbh_ctrl #(
    .DIM (DIM)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_func    (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  dbh_dp #(
    .DIM (DIM)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_func        (in_tuser),
    .in_row         (in_tdata[5:0]),
    .in_col         (in_tdata[11:6]),
    .in_entry_value (in_tdata[43:12]),
    .in_x_old       (in_tdata[75:44]),
    .in_x_new       (in_tdata[107:76]),
    .in_g_old       (in_tdata[139:108]),
    .in_g_new       (in_tdata[171:140]),
    .read_value     (read_value),
    .damping_used   (damping_used),
    .status         (status)
  );

  // Result word packing.
  assign out_tdata = {5'd0, status, damping_used, read_value};

endmodule

// File: src/dbh_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbh_div
// Radix-2 restoring divider, 64-bit signed dividend by 36-bit signed divisor,
// quotient truncated toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dbh_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic signed [35:0] den,
  output logic               busy,
  output logic signed [63:0] quo
);
  import dbh_pkg::*;

  logic        busy_r, busy_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [63:0] n_r, n_nxt;
  logic [35:0] rem_r, rem_nxt;
  logic [35:0] d_r, d_nxt;
  logic        neg_r, neg_nxt;
  logic [36:0] rem_sh;

  // One shift-and-subtract step per cycle.
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    n_nxt    = n_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    neg_nxt  = neg_r;
    rem_sh   = {rem_r, n_r[63]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      n_nxt    = num[63] ? 64'(-num) : 64'(num);
      rem_nxt  = '0;
      d_nxt    = den[35] ? 36'(-den) : 36'(den);
      neg_nxt  = num[63] ^ den[35];
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, d_r}) begin
        rem_nxt = 36'(rem_sh - {1'b0, d_r});
        n_nxt   = {n_r[62:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[35:0];
        n_nxt   = {n_r[62:0], 1'b0};
      end
      cnt_nxt = 6'(cnt_r + 6'd1);
      if (cnt_r == 6'd63) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    n_r   <= n_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
    neg_r <= neg_nxt;
  end

  assign busy = busy_r;
  assign quo  = neg_r ? -$signed(n_r) : $signed(n_r);

endmodule

// File: src/dbh_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbh_ctrl
// Sequencer for the BFGS core: clearing sweep, single-word items and the
// update schedule over the datapath.
// ----------------------------------------------------------------------------
module dbh_ctrl #(
  parameter int DIM = dbh_pkg::DIM_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic [1:0]        in_func,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  dbh_pkg::sts_t     sts,
  output dbh_pkg::cmd_t     cmd
);
  import dbh_pkg::*;

  localparam int IW = $clog2(DIM);

  state_t         state_r, state_nxt;
  logic [IW-1:0]  i_r, i_nxt, j_r, j_nxt;
  logic           ov_r, ov_nxt;
  logic           fire, i_last, j_last;

  assign i_last    = (i_r == IW'(DIM - 1));
  assign j_last    = (j_r == IW'(DIM - 1));
  assign in_tready = (state_r == S_IDLE) && (!ov_r || out_tready);
  assign fire      = in_tvalid && in_tready;

  // Next state and loop counters.
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    case (state_r)
      S_CLEAR: begin
        if (j_last) begin
          j_nxt = '0;
          if (i_last) begin
            i_nxt     = '0;
            state_nxt = S_IDLE;
          end else begin
            i_nxt = IW'(i_r + 1'b1);
          end
        end else begin
          j_nxt = IW'(j_r + 1'b1);
        end
      end
      S_IDLE: begin
        if (fire) begin
          i_nxt = '0;
          j_nxt = '0;
          case (func_t'(in_func))
            FN_WRITE:  state_nxt = S_WR;
            FN_LOAD:   state_nxt = S_LD;
            FN_READ:   state_nxt = S_RD;
            default:   state_nxt = S_HS_CLR;
          endcase
        end
      end
      S_WR, S_LD, S_RD: state_nxt = S_FIN;
      S_HS_CLR: begin
        j_nxt     = '0;
        state_nxt = S_HS_RD;
      end
      S_HS_RD:  state_nxt = S_HS_MUL;
      S_HS_MUL: state_nxt = S_HS_ACC;
      S_HS_ACC: begin
        if (j_last) begin
          state_nxt = S_HS_ST;
        end else begin
          j_nxt     = IW'(j_r + 1'b1);
          state_nxt = S_HS_RD;
        end
      end
      S_HS_ST: begin
        if (i_last) begin
          i_nxt     = '0;
          state_nxt = S_SH_CLR;
        end else begin
          i_nxt     = IW'(i_r + 1'b1);
          state_nxt = S_HS_CLR;
        end
      end
      S_SH_CLR: state_nxt = S_SH_RD;
      S_SH_RD:  state_nxt = S_SH_MUL;
      S_SH_MUL: state_nxt = S_SH_ACC;
      S_SH_ACC: begin
        if (i_last) begin
          i_nxt     = '0;
          state_nxt = S_SH_ST;
        end else begin
          i_nxt     = IW'(i_r + 1'b1);
          state_nxt = S_SH_RD;
        end
      end
      S_SH_ST:  state_nxt = S_SY_CLR;
      S_SY_CLR: state_nxt = S_SY_RD;
      S_SY_RD:  state_nxt = S_SY_MUL;
      S_SY_MUL: state_nxt = S_SY_ACC;
      S_SY_ACC: begin
        if (i_last) begin
          i_nxt     = '0;
          state_nxt = S_SY_ST;
        end else begin
          i_nxt     = IW'(i_r + 1'b1);
          state_nxt = S_SY_RD;
        end
      end
      S_SY_ST: state_nxt = S_TH_CHK;
      S_TH_CHK: begin
        if (sts.shs_zero) begin
          state_nxt = S_FIN_ZD;
        end else if (sts.th_pass) begin
          state_nxt = S_TH_ONE;
        end else if (sts.th_den_zero) begin
          state_nxt = S_FIN_ZD;
        end else begin
          state_nxt = S_TH_DIV;
        end
      end
      S_TH_ONE:  state_nxt = S_OMT;
      S_TH_DIV:  state_nxt = S_TH_WAIT;
      S_TH_WAIT: state_nxt = sts.div_busy ? S_TH_WAIT : S_TH_ST;
      S_TH_ST:   state_nxt = S_OMT;
      S_OMT:     state_nxt = S_R_CLR;
      S_R_CLR:   state_nxt = S_R_RD;
      S_R_RD:    state_nxt = S_R_MTY;
      S_R_MTY:   state_nxt = S_R_ACC1;
      S_R_ACC1:  state_nxt = S_R_MOH;
      S_R_MOH:   state_nxt = S_R_ACC2;
      S_R_ACC2:  state_nxt = S_R_ST;
      S_R_ST: begin
        if (i_last) begin
          i_nxt     = '0;
          state_nxt = S_SR_CLR;
        end else begin
          i_nxt     = IW'(i_r + 1'b1);
          state_nxt = S_R_CLR;
        end
      end
      S_SR_CLR: state_nxt = S_SR_RD;
      S_SR_RD:  state_nxt = S_SR_MUL;
      S_SR_MUL: state_nxt = S_SR_ACC;
      S_SR_ACC: begin
        if (i_last) begin
          i_nxt     = '0;
          state_nxt = S_SR_ST;
        end else begin
          i_nxt     = IW'(i_r + 1'b1);
          state_nxt = S_SR_RD;
        end
      end
      S_SR_ST:  state_nxt = S_SR_CHK;
      S_SR_CHK: state_nxt = sts.sr_zero ? S_FIN_ZD : S_UP_ROW;
      S_UP_ROW: begin
        j_nxt     = '0;
        state_nxt = S_UP_LAT;
      end
      S_UP_LAT:  state_nxt = S_UP_RD;
      S_UP_RD:   state_nxt = S_UP_MHH;
      S_UP_MHH:  state_nxt = S_UP_D1;
      S_UP_D1:   state_nxt = S_UP_MRR;
      S_UP_MRR:  state_nxt = S_UP_D2;
      S_UP_D2:   state_nxt = S_UP_WAIT;
      S_UP_WAIT: state_nxt = sts.div_busy ? S_UP_WAIT : S_UP_WR;
      S_UP_WR: begin
        if (j_last) begin
          if (i_last) begin
            state_nxt = S_FIN;
          end else begin
            i_nxt     = IW'(i_r + 1'b1);
            state_nxt = S_UP_ROW;
          end
        end else begin
          j_nxt     = IW'(j_r + 1'b1);
          state_nxt = S_UP_RD;
        end
      end
      S_FIN, S_FIN_ZD: state_nxt = S_IDLE;
      default:         state_nxt = S_IDLE;
    endcase
  end

  // Datapath commands decoded from the state.
  always_comb begin
    cmd      = '0;
    cmd.op   = OP_NONE;
    cmd.msel = M_HS;
    cmd.ri   = IDX_W'(i_r);
    cmd.rj   = IDX_W'(j_r);
    cmd.vi   = IDX_W'(i_r);
    case (state_r)
      S_CLEAR:  cmd.op = OP_CLR;
      S_IDLE:   cmd.op = fire ? OP_TAKE : OP_NONE;
      S_WR:     cmd.op = OP_WRITE;
      S_LD:     cmd.op = OP_LOAD;
      S_RD:     cmd.op = OP_RDITEM;
      S_HS_CLR, S_SH_CLR, S_SY_CLR, S_R_CLR, S_SR_CLR: cmd.op = OP_ACC_CLR;
      S_HS_RD, S_UP_RD: begin
        cmd.op = OP_RD;
        cmd.vi = IDX_W'(j_r);
      end
      S_SH_RD, S_SY_RD, S_R_RD, S_SR_RD, S_UP_ROW: cmd.op = OP_RD;
      S_HS_MUL: begin
        cmd.op   = OP_MUL;
        cmd.msel = M_HS;
      end
      S_SH_MUL: begin
        cmd.op   = OP_MUL;
        cmd.msel = M_SHS;
      end
      S_SY_MUL: begin
        cmd.op   = OP_MUL;
        cmd.msel = M_SY;
      end
      S_R_MTY: begin
        cmd.op   = OP_MUL;
        cmd.msel = M_TY;
      end
      S_R_MOH: begin
        cmd.op   = OP_MUL;
        cmd.msel = M_OH;
      end
      S_SR_MUL: begin
        cmd.op   = OP_MUL;
        cmd.msel = M_SR;
      end
      S_UP_MHH: begin
        cmd.op   = OP_MUL;
        cmd.msel = M_HH;
      end
      S_UP_MRR: begin
        cmd.op   = OP_MUL;
        cmd.msel = M_RR;
      end
      S_HS_ACC, S_SH_ACC, S_SY_ACC, S_R_ACC1, S_R_ACC2, S_SR_ACC: cmd.op = OP_ACC;
      S_HS_ST:  cmd.op = OP_ST_HS;
      S_SH_ST:  cmd.op = OP_ST_SHS;
      S_SY_ST:  cmd.op = OP_ST_SY;
      S_R_ST:   cmd.op = OP_ST_R;
      S_SR_ST:  cmd.op = OP_ST_SR;
      S_TH_ONE: cmd.op = OP_TH_ONE;
      S_TH_DIV: cmd.op = OP_DIV_TH;
      S_TH_ST:  cmd.op = OP_TH_ST;
      S_OMT:    cmd.op = OP_OMT;
      S_UP_LAT: cmd.op = OP_LATCH;
      S_UP_D1:  cmd.op = OP_DIV1;
      S_UP_D2:  cmd.op = OP_DIV2;
      S_UP_WR:  cmd.op = OP_UPD_WR;
      S_FIN:    cmd.op = OP_FIN;
      S_FIN_ZD: cmd.op = OP_FIN_ZD;
      default:  cmd.op = OP_NONE;
    endcase
  end

  // The result word is held until the sink takes it.
  always_comb begin
    ov_nxt = ov_r;
    if (out_tready) begin
      ov_nxt = 1'b0;
    end
    if ((state_r == S_FIN) || (state_r == S_FIN_ZD)) begin
      ov_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      i_r     <= '0;
      j_r     <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign out_tvalid = ov_r;

endmodule

// File: src/dbh_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbh_dp
// Datapath of the BFGS core: Hessian and vector memories, one 32x32
// multiplier, accumulator, two dividers and the result word registers.
// ----------------------------------------------------------------------------
module dbh_dp #(
  parameter int DIM = dbh_pkg::DIM_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dbh_pkg::cmd_t      cmd,
  output dbh_pkg::sts_t      sts,
  input  logic [1:0]         in_func,
  input  logic [5:0]         in_row,
  input  logic [5:0]         in_col,
  input  logic signed [31:0] in_entry_value,
  input  logic signed [31:0] in_x_old,
  input  logic signed [31:0] in_x_new,
  input  logic signed [31:0] in_g_old,
  input  logic signed [31:0] in_g_new,
  output logic signed [31:0] read_value,
  output logic               damping_used,
  output logic [1:0]         status
);
  import dbh_pkg::*;

  localparam int IW = $clog2(DIM);
  localparam int HD = 1 << (2 * IW);

  // Latched item fields.
  func_t              func_r;
  logic [5:0]         row_r, col_r;
  logic signed [31:0] ent_r, xo_r, xn_r, go_r, gn_r;

  // Storage.
  logic signed [31:0] hmem [HD];
  logic signed [31:0] smem [DIM];
  logic signed [31:0] ymem [DIM];
  logic signed [31:0] hsmem [DIM];
  logic signed [31:0] rmem [DIM];

  logic signed [31:0] h_q_r, s_q_r, y_q_r, hs_q_r, r_q_r;
  logic signed [31:0] hsrow_r, rrow_r;
  logic signed [31:0] shs_r, sy_r, sr_r, theta_r, omt_r;
  logic signed [63:0] prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic               sat_r;
  logic signed [31:0] rv_r;
  logic               damp_r;
  status_t            st_r;

  logic               row_ok, inrange;
  logic [IW-1:0]      vi, ri, rj;
  logic [2*IW-1:0]    h_wa, h_ra;
  logic               h_we;
  logic signed [31:0] h_wd;
  logic signed [32:0] s_dif, y_dif;
  logic signed [31:0] mul_a, mul_b;
  logic signed [47:0] mulq;
  logic signed [31:0] acc_sat;
  logic               acc_ovf;
  logic signed [35:0] sy5, shs36, th_den;
  logic signed [32:0] dif33;
  logic               d1_start, d2_start, d1_busy, d2_busy;
  logic signed [63:0] d1_num, d1_q, d2_q;
  logic signed [35:0] d1_den;
  logic signed [63:0] q1l, q2l, upd64, omt64;

  assign row_ok  = {1'b0, row_r} < 7'(DIM);
  assign inrange = row_ok && ({1'b0, col_r} < 7'(DIM));
  assign vi      = cmd.vi[IW-1:0];
  assign ri      = cmd.ri[IW-1:0];
  assign rj      = cmd.rj[IW-1:0];

  // Hessian memory port selection.
  always_comb begin
    h_we = 1'b0;
    h_wa = {ri, rj};
    h_wd = '0;
    h_ra = {ri, rj};
    case (cmd.op)
      OP_CLR: begin
        h_we = 1'b1;
        h_wd = (ri == rj) ? ONE_Q : 32'sd0;
      end
      OP_WRITE: begin
        h_we = inrange;
        h_wa = {row_r[IW-1:0], col_r[IW-1:0]};
        h_wd = ent_r;
      end
      OP_UPD_WR: begin
        h_we = 1'b1;
        h_wd = sat32(upd64);
      end
      OP_RDITEM: h_ra = {row_r[IW-1:0], col_r[IW-1:0]};
      default:   h_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (h_we) begin
      hmem[h_wa] <= h_wd;
    end
    if ((cmd.op == OP_RD) || (cmd.op == OP_RDITEM)) begin
      h_q_r <= hmem[h_ra];
    end
  end

  // Step and gradient difference vectors.
  assign s_dif = 33'(xn_r) - 33'(xo_r);
  assign y_dif = 33'(gn_r) - 33'(go_r);

  always_ff @(posedge clk) begin
    if ((cmd.op == OP_LOAD) && row_ok) begin
      smem[row_r[IW-1:0]] <= sat32(64'(s_dif));
      ymem[row_r[IW-1:0]] <= sat32(64'(y_dif));
    end
    if (cmd.op == OP_RD) begin
      s_q_r <= smem[vi];
      y_q_r <= ymem[vi];
    end
  end

  // Hs and r vectors.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_ST_HS) begin
      hsmem[vi] <= acc_sat;
    end
    if (cmd.op == OP_ST_R) begin
      rmem[vi] <= acc_sat;
    end
    if (cmd.op == OP_RD) begin
      hs_q_r <= hsmem[vi];
      r_q_r  <= rmem[vi];
    end
  end

  // Multiplier operand selection.
  always_comb begin
    case (cmd.msel)
      M_HS: begin
        mul_a = h_q_r;
        mul_b = s_q_r;
      end
      M_SHS: begin
        mul_a = s_q_r;
        mul_b = hs_q_r;
      end
      M_SY: begin
        mul_a = s_q_r;
        mul_b = y_q_r;
      end
      M_TY: begin
        mul_a = theta_r;
        mul_b = y_q_r;
      end
      M_OH: begin
        mul_a = omt_r;
        mul_b = hs_q_r;
      end
      M_SR: begin
        mul_a = s_q_r;
        mul_b = r_q_r;
      end
      M_HH: begin
        mul_a = hsrow_r;
        mul_b = hs_q_r;
      end
      M_RR: begin
        mul_a = rrow_r;
        mul_b = r_q_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Floor shift of the product, then accumulate and clamp.
  assign mulq    = 48'(prod_r >>> 16);
  assign acc_sat = sat32(64'(acc_r));
  assign acc_ovf = ovf32(64'(acc_r));

  // Damping test and theta divisor.
  assign shs36  = 36'(shs_r);
  assign sy5    = (36'(sy_r) <<< 2) + 36'(sy_r);
  assign dif33  = 33'(shs_r) - 33'(sy_r);
  assign th_den = (36'(dif33) <<< 2) + 36'(dif33);

  assign sts.shs_zero    = (shs_r == 32'sd0);
  assign sts.th_pass     = (sy5 >= shs36);
  assign sts.th_den_zero = (th_den == 36'sd0);
  assign sts.sr_zero     = (sr_r == 32'sd0);
  assign sts.div_busy    = d1_busy || d2_busy;

  // Dividers: theta and the Hs correction share the first one.
  assign d1_start = (cmd.op == OP_DIV_TH) || (cmd.op == OP_DIV1);
  assign d2_start = (cmd.op == OP_DIV2);
  assign d1_num   = (cmd.op == OP_DIV_TH) ? (64'(shs_r) <<< 18) : prod_r;
  assign d1_den   = (cmd.op == OP_DIV_TH) ? th_den : shs36;

  dbh_div u_div1 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (d1_start),
    .num   (d1_num),
    .den   (d1_den),
    .busy  (d1_busy),
    .quo   (d1_q)
  );

  dbh_div u_div2 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (d2_start),
    .num   (prod_r),
    .den   (36'(sr_r)),
    .busy  (d2_busy),
    .quo   (d2_q)
  );

  // New Hessian entry from the two corrections.
  assign q1l   = lim61(d1_q);
  assign q2l   = lim61(d2_q);
  assign upd64 = 64'(h_q_r) - q1l + q2l;
  assign omt64 = 64'(ONE_Q) - 64'(theta_r);

  // Working registers.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_TAKE: begin
        func_r <= func_t'(in_func);
        row_r  <= in_row;
        col_r  <= in_col;
        ent_r  <= in_entry_value;
        xo_r   <= in_x_old;
        xn_r   <= in_x_new;
        go_r   <= in_g_old;
        gn_r   <= in_g_new;
      end
      OP_MUL:     prod_r  <= mul_a * mul_b;
      OP_ACC_CLR: acc_r   <= '0;
      OP_ACC:     acc_r   <= acc_r + ACC_W'(mulq);
      OP_ST_SHS:  shs_r   <= acc_sat;
      OP_ST_SY:   sy_r    <= acc_sat;
      OP_ST_SR:   sr_r    <= acc_sat;
      OP_TH_ONE:  theta_r <= ONE_Q;
      OP_TH_ST:   theta_r <= sat32(d1_q);
      OP_OMT:     omt_r   <= sat32(omt64);
      OP_LATCH: begin
        hsrow_r <= hs_q_r;
        rrow_r  <= r_q_r;
      end
      default: ;
    endcase
  end

  // Saturation flag and result word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r  <= 1'b0;
      rv_r   <= '0;
      damp_r <= 1'b0;
      st_r   <= ST_OK;
    end else begin
      case (cmd.op)
        OP_TAKE: sat_r <= 1'b0;
        OP_LOAD: begin
          if (row_ok && (ovf32(64'(s_dif)) || ovf32(64'(y_dif)))) begin
            sat_r <= 1'b1;
          end
        end
        OP_ST_HS, OP_ST_SHS, OP_ST_SY, OP_ST_R, OP_ST_SR: begin
          if (acc_ovf) begin
            sat_r <= 1'b1;
          end
        end
        OP_TH_ST: begin
          if (ovf32(d1_q)) begin
            sat_r <= 1'b1;
          end
        end
        OP_OMT: begin
          if (ovf32(omt64)) begin
            sat_r <= 1'b1;
          end
        end
        OP_UPD_WR: begin
          if (ovf61(d1_q) || ovf61(d2_q) || ovf32(upd64)) begin
            sat_r <= 1'b1;
          end
        end
        OP_FIN: begin
          rv_r   <= ((func_r == FN_READ) && inrange) ? h_q_r : 32'sd0;
          damp_r <= (func_r == FN_UPDATE) && (theta_r < ONE_Q);
          st_r   <= sat_r ? ST_SAT : ST_OK;
        end
        OP_FIN_ZD: begin
          rv_r   <= '0;
          damp_r <= 1'b0;
          st_r   <= ST_ZDEN;
        end
        default: ;
      endcase
    end
  end

  assign read_value   = rv_r;
  assign damping_used = damp_r;
  assign status       = st_r;

endmodule
